[src/mahp_pkg.sv]
`timescale 1ns / 1ps

package mahp_pkg;

    // Work handed from the byte parser to the header decoder.
    typedef struct packed {
        logic        is_trunc;  // buffer ended before a header was complete
        logic [23:0] header;    // three frame-header bytes, first byte on top
        logic [29:0] offset;    // size of first ID3 tag, 0 if none
    } mahp_job_t;

endpackage

[src/mahp_front.sv]
`timescale 1ns / 1ps

module mahp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          byte_in,
    input  logic                last_byte,
    input  logic                q_full,
    output logic                push,
    output mahp_pkg::mahp_job_t push_job
);
    import mahp_pkg::*;

    localparam logic [1:0]  PH_HEAD   = 2'd0;
    localparam logic [1:0]  PH_TAG    = 2'd1;
    localparam logic [1:0]  PH_SKIP   = 2'd2;
    localparam logic [23:0] ID3_MAGIC = 24'h494433;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [29:0] acc_reg, acc_next;
    logic [29:0] skip_reg, skip_next;
    logic [29:0] off_reg, off_next;
    logic [23:0] hdr_reg, hdr_next;
    logic        sent_reg, sent_next;
    logic        in_fire;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        logic [3:0]  idx_inc;
        logic [29:0] skip_dec;
        logic        do_decode;
        logic        do_trunc;

        idx_inc    = idx_reg + 4'd1;
        skip_dec   = (skip_reg != 30'd0) ? skip_reg - 30'd1 : 30'd0;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        skip_next  = skip_reg;
        off_next   = off_reg;
        hdr_next   = hdr_reg;
        sent_next  = sent_reg;
        do_decode  = 1'b0;
        do_trunc   = 1'b0;

        if (!sent_reg)
        begin
            case (phase_reg)
                PH_TAG:
                begin
                    // bytes 6..9 are full bytes weighted by 128
                    if (idx_reg == 4'd6)
                        acc_next = {22'd0, byte_in};
                    else if (idx_reg > 4'd6)
                        acc_next = {acc_reg[22:0], 7'd0} + {22'd0, byte_in};
                    if (idx_inc >= 4'd10)
                    begin
                        if (off_reg == 30'd0)
                            off_next = acc_next + 30'd10;
                        idx_next = 4'd0;
                        hdr_next = 24'd0;
                        if (acc_next == 30'd0)
                            phase_next = PH_HEAD;
                        else
                        begin
                            skip_next  = acc_next;
                            phase_next = PH_SKIP;
                        end
                    end
                    else
                        idx_next = idx_inc;
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 30'd0)
                    begin
                        phase_next = PH_HEAD;
                        idx_next   = 4'd0;
                        hdr_next   = 24'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_HEAD;
                    hdr_next   = {hdr_reg[15:0], byte_in};
                    idx_next   = idx_inc;
                    if (idx_inc >= 4'd3)
                    begin
                        if (hdr_next == ID3_MAGIC)
                        begin
                            phase_next = PH_TAG;
                            idx_next   = 4'd3;
                            acc_next   = 30'd0;
                        end
                        else
                        begin
                            do_decode = 1'b1;
                            sent_next = 1'b1;
                        end
                    end
                end
            endcase
        end

        push_job.is_trunc = 1'b0;
        push_job.header   = hdr_next;
        push_job.offset   = off_next;

        if (last_byte)
        begin
            if (!sent_next)
            begin
                do_trunc          = 1'b1;
                push_job.is_trunc = 1'b1;
            end
            phase_next = PH_HEAD;
            idx_next   = 4'd0;
            acc_next   = 30'd0;
            skip_next  = 30'd0;
            off_next   = 30'd0;
            hdr_next   = 24'd0;
            sent_next  = 1'b0;
        end

        push = in_fire && (do_decode || do_trunc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            idx_reg   <= 4'd0;
            acc_reg   <= 30'd0;
            skip_reg  <= 30'd0;
            off_reg   <= 30'd0;
            hdr_reg   <= 24'd0;
            sent_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            skip_reg  <= skip_next;
            off_reg   <= off_next;
            hdr_reg   <= hdr_next;
            sent_reg  <= sent_next;
        end
    end

    a_tag_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TAG |-> (idx_reg >= 4'd3 && idx_reg <= 4'd9))
        else $error("tag byte index out of range");

    a_sent_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (sent_reg && !(in_fire && last_byte)) |=> sent_reg)
        else $error("result flag cleared before end of buffer");

endmodule

[src/mahp_queue.sv]
`timescale 1ns / 1ps

module mahp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mahp_pkg::mahp_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output mahp_pkg::mahp_job_t pop_job
);
    import mahp_pkg::*;

    mahp_job_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |-> pop)
        else $error("job queue overflow");

endmodule

[src/mahp_back.sv]
`timescale 1ns / 1ps

module mahp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  mahp_pkg::mahp_job_t q_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          status,
    output logic [29:0]         audio_offset,
    output logic [15:0]         sample_hz,
    output logic [18:0]         bit_rate,
    output logic [10:0]         frame_samples,
    output logic [10:0]         frame_bytes
);
    import mahp_pkg::*;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SYNC    = 3'd1;
    localparam logic [2:0] ST_TRUNC   = 3'd2;
    localparam logic [2:0] ST_RATE    = 3'd3;
    localparam logic [2:0] ST_BITRATE = 3'd4;

    localparam logic BK_IDLE = 1'b0;
    localparam logic BK_DIV  = 1'b1;

    localparam int         DIV_STEPS = 11;
    localparam logic [3:0] DIV_LAST  = 4'(DIV_STEPS - 1);

    // layer III bitrate in bit/s; lsf selects the MPEG2/2.5 column
    function automatic logic [18:0] bitrate_bps(input logic lsf, input logic [3:0] idx);
        logic [18:0] r;
        r = 19'd0;
        if (!lsf)
        begin
            case (idx)
                4'd1:    r = 19'd32000;
                4'd2:    r = 19'd40000;
                4'd3:    r = 19'd48000;
                4'd4:    r = 19'd56000;
                4'd5:    r = 19'd64000;
                4'd6:    r = 19'd80000;
                4'd7:    r = 19'd96000;
                4'd8:    r = 19'd112000;
                4'd9:    r = 19'd128000;
                4'd10:   r = 19'd160000;
                4'd11:   r = 19'd192000;
                4'd12:   r = 19'd224000;
                4'd13:   r = 19'd256000;
                4'd14:   r = 19'd320000;
                default: r = 19'd0;
            endcase
        end
        else
        begin
            case (idx)
                4'd1:    r = 19'd8000;
                4'd2:    r = 19'd16000;
                4'd3:    r = 19'd24000;
                4'd4:    r = 19'd32000;
                4'd5:    r = 19'd40000;
                4'd6:    r = 19'd48000;
                4'd7:    r = 19'd56000;
                4'd8:    r = 19'd64000;
                4'd9:    r = 19'd80000;
                4'd10:   r = 19'd96000;
                4'd11:   r = 19'd112000;
                4'd12:   r = 19'd128000;
                4'd13:   r = 19'd144000;
                4'd14:   r = 19'd160000;
                default: r = 19'd0;
            endcase
        end
        return r;
    endfunction

    // ver: 0 MPEG1, 1 MPEG2, 2 MPEG2.5
    function automatic logic [15:0] rate_hz(input logic [1:0] ver, input logic [1:0] idx);
        logic [15:0] r;
        r = 16'd0;
        case ({ver, idx})
            4'b00_00: r = 16'd44100;
            4'b00_01: r = 16'd48000;
            4'b00_10: r = 16'd32000;
            4'b01_00: r = 16'd22050;
            4'b01_01: r = 16'd24000;
            4'b01_10: r = 16'd16000;
            4'b10_00: r = 16'd11025;
            4'b10_01: r = 16'd12000;
            4'b10_10: r = 16'd8000;
            default:  r = 16'd0;
        endcase
        return r;
    endfunction

    logic        state_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [10:0] dvd_reg;
    logic        pad_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  status_reg;
    logic [29:0] offset_reg;
    logic [15:0] sr_reg;
    logic [18:0] br_reg;
    logic [10:0] dur_reg;
    logic [10:0] fb_reg;

    logic [2:0]  dec_status;
    logic [15:0] dec_sr;
    logic [18:0] dec_br;
    logic [10:0] dec_dur;
    logic [25:0] dec_prod;
    logic        dec_pad;
    logic [15:0] rem_next;
    logic [10:0] dvd_next;

    always_comb
    begin
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] vcode;
        logic [1:0] ver;
        logic       lsf;
        logic       bad;

        b0    = q_job.header[23:16];
        b1    = q_job.header[15:8];
        b2    = q_job.header[7:0];
        vcode = b1[4:3];
        bad   = (b0 != 8'hFF) || (b1[7:5] != 3'b111) || (vcode == 2'b01);
        lsf   = (vcode != 2'b11);
        ver   = (vcode == 2'b11) ? 2'd0 : (vcode == 2'b10) ? 2'd1 : 2'd2;

        if (q_job.is_trunc)
            dec_status = ST_TRUNC;
        else if (bad)
            dec_status = ST_SYNC;
        else if (b2[3:2] == 2'b11)
            dec_status = ST_RATE;
        else if (b2[7:4] == 4'hF)
            dec_status = ST_BITRATE;
        else
            dec_status = ST_OK;

        dec_br   = bitrate_bps(lsf, b2[7:4]);
        dec_sr   = rate_hz(ver, b2[3:2]);
        dec_dur  = lsf ? 11'd576 : 11'd1152;
        dec_pad  = b2[1];
        // (duration / 8) * bitrate, at most 144 * 320000
        dec_prod = {7'd0, dec_br} * (lsf ? 26'd72 : 26'd144);
    end

    // one quotient bit per cycle; quotient is known to fit in 11 bits
    always_comb
    begin
        logic [16:0] trial;
        logic        ge;

        trial    = {rem_reg, dvd_reg[10]};
        ge       = (trial >= {1'b0, sr_reg});
        rem_next = ge ? 16'(trial - {1'b0, sr_reg}) : trial[15:0];
        dvd_next = {dvd_reg[9:0], ge};
    end

    assign pop = (state_reg == BK_IDLE) && !q_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (pop && dec_status != ST_OK)
            out_valid_next = 1'b1;
        else if (state_reg == BK_DIV && cnt_reg == DIV_LAST)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= 4'd0;
            rem_reg       <= 16'd0;
            dvd_reg       <= 11'd0;
            pad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            offset_reg    <= 30'd0;
            sr_reg        <= 16'd0;
            br_reg        <= 19'd0;
            dur_reg       <= 11'd0;
            fb_reg        <= 11'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                BK_IDLE:
                begin
                    if (pop)
                    begin
                        status_reg <= dec_status;
                        offset_reg <= q_job.offset;
                        if (dec_status == ST_OK)
                        begin
                            sr_reg    <= dec_sr;
                            br_reg    <= dec_br;
                            dur_reg   <= dec_dur;
                            pad_reg   <= dec_pad;
                            rem_reg   <= {1'b0, dec_prod[25:11]};
                            dvd_reg   <= dec_prod[10:0];
                            cnt_reg   <= 4'd0;
                            state_reg <= BK_DIV;
                        end
                        else
                        begin
                            sr_reg  <= 16'd0;
                            br_reg  <= 19'd0;
                            dur_reg <= 11'd0;
                            fb_reg  <= 11'd0;
                        end
                    end
                end
                BK_DIV:
                begin
                    rem_reg <= rem_next;
                    dvd_reg <= dvd_next;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        fb_reg    <= dvd_next + {10'd0, pad_reg};
                        state_reg <= BK_IDLE;
                    end
                end
                default:
                    state_reg <= BK_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign audio_offset  = offset_reg;
    assign sample_hz     = sr_reg;
    assign bit_rate      = br_reg;
    assign frame_samples = dur_reg;
    assign frame_bytes   = fb_reg;

    a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIV |-> !out_valid_reg)
        else $error("result shown while division in progress");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |->
            (sr_reg == 16'd0 && br_reg == 19'd0 && fb_reg == 11'd0))
        else $error("error result carries nonzero fields");

endmodule

[src/mpeg_audio_header_parser.sv]
// An error or truncated result goes from the byte that decides it into the job queue, is popped
// and is registered as the result; a good header first passes through the bit-serial frame-size divider.
// Throughput: one byte per cycle; the divider takes no new job until the current one is done,
// with a 2-deep job queue so short buffers stall input only when it fills.
// Reset (rst_n low, asynchronous): parser back at start of buffer, queue empty, no result.
`timescale 1ns / 1ps

module mpeg_audio_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [29:0] audio_offset,
    output logic [15:0] sample_hz,
    output logic [18:0] bit_rate,
    output logic [10:0] frame_samples,
    output logic [10:0] frame_bytes
);
    import mahp_pkg::*;

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    mahp_job_t push_job;
    mahp_job_t pop_job;

    mahp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .byte_in   (byte_in),
        .last_byte (last_byte),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    mahp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    mahp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_job         (pop_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .audio_offset  (audio_offset),
        .sample_hz     (sample_hz),
        .bit_rate      (bit_rate),
        .frame_samples (frame_samples),
        .frame_bytes   (frame_bytes)
    );

endmodule
